// ===== hw/rtl/gtpu_pkg.sv =====
package gtpu_pkg;

   localparam int HEADER_BYTES    = 58;
   localparam int FRAME_LIMIT_DEF = 1500;
   localparam int FIFO_DEPTH      = 4;
   localparam int HDR_IDX_W       = $clog2(HEADER_BYTES + 1);

   // register indexes on the csr port
   localparam logic [2:0] CSR_TUNNEL_ID = 3'd0;
   localparam logic [2:0] CSR_FLOW_QFI  = 3'd1;
   localparam logic [2:0] CSR_SRC_MAC   = 3'd2;
   localparam logic [2:0] CSR_DST_MAC   = 3'd3;
   localparam logic [2:0] CSR_SRC_IP    = 3'd4;
   localparam logic [2:0] CSR_DST_IP    = 3'd5;

   localparam logic [31:0] TUNNEL_ID_RST = 32'h0000_1001;
   localparam logic [5:0]  FLOW_QFI_RST  = 6'd5;
   localparam logic [47:0] SRC_MAC_RST   = 48'hA036_9FBA_36AC;
   localparam logic [47:0] DST_MAC_RST   = 48'hE41D_2D09_A830;
   localparam logic [31:0] SRC_IP_RST    = 32'hC0A8_2C0D;
   localparam logic [31:0] DST_IP_RST    = 32'hC0A8_2C12;

   localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  IP_VER_IHL    = 8'h45;
   localparam logic [7:0]  IP_TTL        = 8'd64;
   localparam logic [7:0]  IP_PROTO_UDP  = 8'd17;
   localparam logic [15:0] UDP_SRC_PORT  = 16'd12345;
   localparam logic [15:0] UDP_DST_PORT  = 16'd2152;
   localparam logic [7:0]  GTP_FLAGS     = 8'h34;
   localparam logic [7:0]  GTP_MSG_TPDU  = 8'hFF;
   localparam logic [7:0]  GTP_EXT_PDU   = 8'h85;
   localparam logic [7:0]  GTP_EXT_LEN   = 8'h01;
   localparam logic [7:0]  PDU_TYPE_UL   = 8'h10;
   localparam logic [15:0] IP_LEN_BASE   = 16'd44;
   localparam logic [15:0] UDP_LEN_BASE  = 16'd24;
   localparam logic [15:0] GTP_LEN_BASE  = 16'd8;
   // constant IPv4 header words: version/ihl/tos plus ttl/proto
   localparam logic [18:0] IP_SUM_BASE   = 19'({IP_VER_IHL, 8'h00}) +
                                           19'({IP_TTL, IP_PROTO_UDP});

   typedef struct packed {
      logic [31:0] tunnel_id;
      logic [5:0]  flow_qfi;
      logic [47:0] src_mac;
      logic [47:0] dst_mac;
      logic [31:0] src_ip;
      logic [31:0] dst_ip;
      logic [18:0] ip_sum;   // partial checksum without total length
   } cfg_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic        first;
      logic        last;
      logic [15:0] kept;
   } entry_type;

endpackage

// ===== hw/rtl/gtpu_front.sv =====
module gtpu_front #(
   parameter int FRAME_LIMIT = gtpu_pkg::FRAME_LIMIT_DEF
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_data_byte,
   input  logic [15:0]         req_packet_length,
   input  logic                fifo_full,
   output logic                push,
   output gtpu_pkg::entry_type push_entry
);
   import gtpu_pkg::*;

   localparam int          KEPT_W   = $clog2(FRAME_LIMIT - HEADER_BYTES + 1);
   localparam logic [15:0] MAX_KEPT = 16'(FRAME_LIMIT - HEADER_BYTES);

   logic [15:0]       pos_ff, pos_in;
   logic [15:0]       latched_ff, latched_in;
   logic [KEPT_W-1:0] kept_ff, kept_in;
   logic              accept;
   logic              first;
   logic [15:0]       len;
   logic [15:0]       kept16;
   logic [15:0]       pos_inc;

   assign req_stall = fifo_full;
   assign accept    = req_valid && !fifo_full;
   assign first     = (pos_ff == 16'd0);
   assign len       = (req_packet_length == 16'd0) ? 16'd1 : req_packet_length;
   assign pos_inc   = pos_ff + 16'd1;

   always_comb begin
      latched_in = latched_ff;
      kept_in    = kept_ff;
      if (first) begin
         latched_in = len;
         kept_in    = (len > MAX_KEPT) ? MAX_KEPT[KEPT_W-1:0] : len[KEPT_W-1:0];
      end
      kept16 = {{(16 - KEPT_W){1'b0}}, kept_in};
      pos_in = (pos_inc >= latched_in) ? 16'd0 : pos_inc;
   end

   assign push                 = accept && (pos_ff < kept16);
   assign push_entry.data_byte = req_data_byte;
   assign push_entry.first     = first;
   assign push_entry.last      = (pos_inc == kept16);
   assign push_entry.kept      = kept16;

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         latched_ff <= '0;
         kept_ff    <= '0;
      end else if (accept) begin
         pos_ff     <= pos_in;
         latched_ff <= latched_in;
         kept_ff    <= kept_in;
      end
   end

endmodule

// ===== hw/rtl/gtpu_fifo.sv =====
module gtpu_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  gtpu_pkg::entry_type push_entry,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output gtpu_pkg::entry_type head
);
   import gtpu_pkg::*;

   localparam int PTR_W = $clog2(FIFO_DEPTH);
   localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

   entry_type        mem_ff [FIFO_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;

   assign full       = (count_ff == CNT_W'(FIFO_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");
`endif

endmodule

// ===== hw/rtl/gtpu_back.sv =====
module gtpu_back (
   input  logic                clock,
   input  logic                reset,
   input  gtpu_pkg::cfg_type   cfg,
   input  logic                head_valid,
   input  gtpu_pkg::entry_type head,
   output logic                pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_frame_byte,
   output logic                rsp_frame_last
);
   import gtpu_pkg::*;

   logic [HDR_IDX_W-1:0] hdr_cnt_ff, hdr_cnt_in;
   logic [18:0]          sum_ff;
   logic                 valid_ff, valid_in;
   logic [7:0]           byte_ff, byte_in;
   logic                 last_ff, last_in;
   logic                 advance;
   logic                 in_hdr;
   logic [7:0]           hdr_byte;
   logic [15:0]          ip_len, udp_len, gtp_len;
   logic [16:0]          fold1;
   logic [16:0]          fold2;
   logic [15:0]          csum;

   assign advance = !valid_ff || !rsp_stall;
   assign in_hdr  = head.first && (hdr_cnt_ff < HDR_IDX_W'(HEADER_BYTES));
   assign pop     = advance && head_valid && !in_hdr;

   assign ip_len  = IP_LEN_BASE + head.kept;
   assign udp_len = UDP_LEN_BASE + head.kept;
   assign gtp_len = GTP_LEN_BASE + head.kept;

   // end-around carry fold of the registered sum
   assign fold1 = {1'b0, sum_ff[15:0]} + {14'd0, sum_ff[18:16]};
   assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
   assign csum  = ~fold2[15:0];

   always_comb begin
      case (hdr_cnt_ff)
         6'd0:    hdr_byte = cfg.dst_mac[47:40];
         6'd1:    hdr_byte = cfg.dst_mac[39:32];
         6'd2:    hdr_byte = cfg.dst_mac[31:24];
         6'd3:    hdr_byte = cfg.dst_mac[23:16];
         6'd4:    hdr_byte = cfg.dst_mac[15:8];
         6'd5:    hdr_byte = cfg.dst_mac[7:0];
         6'd6:    hdr_byte = cfg.src_mac[47:40];
         6'd7:    hdr_byte = cfg.src_mac[39:32];
         6'd8:    hdr_byte = cfg.src_mac[31:24];
         6'd9:    hdr_byte = cfg.src_mac[23:16];
         6'd10:   hdr_byte = cfg.src_mac[15:8];
         6'd11:   hdr_byte = cfg.src_mac[7:0];
         6'd12:   hdr_byte = ETH_TYPE_IPV4[15:8];
         6'd13:   hdr_byte = ETH_TYPE_IPV4[7:0];
         6'd14:   hdr_byte = IP_VER_IHL;
         6'd16:   hdr_byte = ip_len[15:8];
         6'd17:   hdr_byte = ip_len[7:0];
         6'd22:   hdr_byte = IP_TTL;
         6'd23:   hdr_byte = IP_PROTO_UDP;
         6'd24:   hdr_byte = csum[15:8];
         6'd25:   hdr_byte = csum[7:0];
         6'd26:   hdr_byte = cfg.src_ip[31:24];
         6'd27:   hdr_byte = cfg.src_ip[23:16];
         6'd28:   hdr_byte = cfg.src_ip[15:8];
         6'd29:   hdr_byte = cfg.src_ip[7:0];
         6'd30:   hdr_byte = cfg.dst_ip[31:24];
         6'd31:   hdr_byte = cfg.dst_ip[23:16];
         6'd32:   hdr_byte = cfg.dst_ip[15:8];
         6'd33:   hdr_byte = cfg.dst_ip[7:0];
         6'd34:   hdr_byte = UDP_SRC_PORT[15:8];
         6'd35:   hdr_byte = UDP_SRC_PORT[7:0];
         6'd36:   hdr_byte = UDP_DST_PORT[15:8];
         6'd37:   hdr_byte = UDP_DST_PORT[7:0];
         6'd38:   hdr_byte = udp_len[15:8];
         6'd39:   hdr_byte = udp_len[7:0];
         6'd42:   hdr_byte = GTP_FLAGS;
         6'd43:   hdr_byte = GTP_MSG_TPDU;
         6'd44:   hdr_byte = gtp_len[15:8];
         6'd45:   hdr_byte = gtp_len[7:0];
         6'd46:   hdr_byte = cfg.tunnel_id[31:24];
         6'd47:   hdr_byte = cfg.tunnel_id[23:16];
         6'd48:   hdr_byte = cfg.tunnel_id[15:8];
         6'd49:   hdr_byte = cfg.tunnel_id[7:0];
         6'd53:   hdr_byte = GTP_EXT_PDU;
         6'd54:   hdr_byte = GTP_EXT_LEN;
         6'd55:   hdr_byte = PDU_TYPE_UL;
         6'd56:   hdr_byte = {2'b00, cfg.flow_qfi};
         default: hdr_byte = 8'h00;
      endcase
   end

   always_comb begin
      valid_in   = valid_ff;
      byte_in    = byte_ff;
      last_in    = last_ff;
      hdr_cnt_in = hdr_cnt_ff;
      if (advance) begin
         valid_in = head_valid;
         if (head_valid) begin
            if (in_hdr) begin
               byte_in    = hdr_byte;
               last_in    = 1'b0;
               hdr_cnt_in = hdr_cnt_ff + 1'b1;
            end else begin
               byte_in    = head.data_byte;
               last_in    = head.last;
               hdr_cnt_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         hdr_cnt_ff <= '0;
      end else begin
         valid_ff   <= valid_in;
         hdr_cnt_ff <= hdr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      last_ff <= last_in;
      if (advance && head_valid && in_hdr && (hdr_cnt_ff == '0)) begin
         sum_ff <= cfg.ip_sum + {3'd0, ip_len};
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_frame_byte = byte_ff;
   assign rsp_frame_last = last_ff;

`ifndef ASSERT_OFF
   a_hdr_bound: assert property (@(posedge clock) disable iff (reset)
      hdr_cnt_ff <= HDR_IDX_W'(HEADER_BYTES))
      else $error("header counter past header length");
   a_hdr_owner: assert property (@(posedge clock) disable iff (reset)
      (hdr_cnt_ff != '0) |-> (head_valid && head.first))
      else $error("header in progress without its first byte at queue head");
   a_hdr_done: assert property (@(posedge clock) disable iff (reset)
      (pop && head.first) |-> (hdr_cnt_ff == HDR_IDX_W'(HEADER_BYTES)))
      else $error("first byte left before full header");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && rsp_stall) |=> (valid_ff && $stable(byte_ff)))
      else $error("stalled output changed");
`endif

endmodule

// ===== hw/rtl/gtpu_tunnel_encapsulator_unit.sv =====
// GTP-U encapsulator: inner packet bytes enter on req_ (each tagged with its
// packet length), the outer frame leaves on rsp_ one byte per transaction.
// The first byte of a packet triggers a 58-byte Ethernet/IPv4/UDP/GTP-U header
// ahead of it; the payload is cut at FRAME_LIMIT - 58 bytes, bytes past the cut
// are absorbed with no output, and frame_last marks the last kept byte. The
// front end takes one input byte per cycle into a 4-entry queue; the back end
// emits one output byte per cycle unless the receiver stalls, and the frame
// for a packet of k kept bytes is k + 58 bytes long. Input stalls whenever the
// queue is full: while a header is being emitted, or when the receiver stalls
// the output. Registers are written on csr_ (always ready); a header reads
// them directly, but its checksum reads them through one more register, ip_sum_ff.
module gtpu_tunnel_encapsulator_unit #(
   parameter int FRAME_LIMIT = gtpu_pkg::FRAME_LIMIT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic [15:0] req_packet_length,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_frame_byte,
   output logic        rsp_frame_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);
   import gtpu_pkg::*;

   logic [31:0] tunnel_id_ff;
   logic [5:0]  flow_qfi_ff;
   logic [47:0] src_mac_ff;
   logic [47:0] dst_mac_ff;
   logic [31:0] src_ip_ff;
   logic [31:0] dst_ip_ff;
   logic [18:0] ip_sum_ff, ip_sum_in;
   logic        csr_wr;
   cfg_type     cfg;
   logic        fifo_full;
   logic        push;
   entry_type   push_entry;
   logic        pop;
   logic        head_valid;
   entry_type   head;

   assign csr_ready = 1'b1;
   assign csr_wr    = csr_valid && csr_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         tunnel_id_ff <= TUNNEL_ID_RST;
         flow_qfi_ff  <= FLOW_QFI_RST;
         src_mac_ff   <= SRC_MAC_RST;
         dst_mac_ff   <= DST_MAC_RST;
         src_ip_ff    <= SRC_IP_RST;
         dst_ip_ff    <= DST_IP_RST;
      end else if (csr_wr) begin
         case (csr_index)
            CSR_TUNNEL_ID: tunnel_id_ff <= csr_data[31:0];
            CSR_FLOW_QFI:  flow_qfi_ff  <= csr_data[5:0];
            CSR_SRC_MAC:   src_mac_ff   <= csr_data;
            CSR_DST_MAC:   dst_mac_ff   <= csr_data;
            CSR_SRC_IP:    src_ip_ff    <= csr_data[31:0];
            CSR_DST_IP:    dst_ip_ff    <= csr_data[31:0];
            default:       ;
         endcase
      end
   end

   // constant and address part of the IPv4 checksum, refreshed every cycle
   assign ip_sum_in = IP_SUM_BASE + {3'd0, src_ip_ff[31:16]} + {3'd0, src_ip_ff[15:0]}
                    + {3'd0, dst_ip_ff[31:16]} + {3'd0, dst_ip_ff[15:0]};

   always_ff @(posedge clock) begin
      ip_sum_ff <= ip_sum_in;
   end

   assign cfg.tunnel_id = tunnel_id_ff;
   assign cfg.flow_qfi  = flow_qfi_ff;
   assign cfg.src_mac   = src_mac_ff;
   assign cfg.dst_mac   = dst_mac_ff;
   assign cfg.src_ip    = src_ip_ff;
   assign cfg.dst_ip    = dst_ip_ff;
   assign cfg.ip_sum    = ip_sum_ff;

   gtpu_front #(
      .FRAME_LIMIT (FRAME_LIMIT)
   ) u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_packet_length (req_packet_length),
      .fifo_full         (fifo_full),
      .push              (push),
      .push_entry        (push_entry)
   );

   gtpu_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (fifo_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   gtpu_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .head_valid     (head_valid),
      .head           (head),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_byte (rsp_frame_byte),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

// ===== test/tb_gtpu_tunnel_encapsulator_unit.sv =====
module tb_gtpu_tunnel_encapsulator_unit;
   timeunit 1ns;
   timeprecision 1ps;

   import gtpu_pkg::*;

   localparam int FRAME_MAX   = 1500;
   localparam int HDR_LEN     = 58;
   localparam int MAX_PAYLOAD = FRAME_MAX - HDR_LEN;
   localparam int FLUSH_WAIT  = 16;
   localparam int MAX_REPORTS = 10;

   // indexes with no register behind them
   localparam logic [2:0] CSR_SPARE_LO = 3'd6;
   localparam logic [2:0] CSR_SPARE_HI = 3'd7;

   typedef enum int {FILL_ONES, FILL_ZEROS, FILL_RANDOM} fill_kind_type;

   typedef struct packed {
      logic [7:0]  data_byte;
      logic [15:0] packet_length;
   } inner_item_type;

   typedef struct packed {
      logic [7:0] fbyte;
      logic       last;
   } frame_beat_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_data_byte = 8'h00;
   logic [15:0] req_packet_length = 16'h0000;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [7:0]  rsp_frame_byte;
   logic        rsp_frame_last;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = 3'd0;
   logic [47:0] csr_data = 48'h0;

   inner_item_type inner_q[$];
   frame_beat_type frame_q[$];

   int send_idle_pct = 0;
   int stall_pct = 0;
   int fail_count = 0;
   bit hold_armed = 1'b0;
   logic hold_off = 1'b0;

   // shadow of the register file
   logic [31:0] teid_m = TUNNEL_ID_RST;
   logic [5:0]  qfi_m  = FLOW_QFI_RST;
   logic [47:0] smac_m = SRC_MAC_RST;
   logic [47:0] dmac_m = DST_MAC_RST;
   logic [31:0] sip_m  = SRC_IP_RST;
   logic [31:0] dip_m  = DST_IP_RST;

   // packet tracking
   int          payload_pos = 0;
   int          kept_len = 0;
   int          latched_len = 0;

   gtpu_tunnel_encapsulator_unit u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_packet_length (req_packet_length),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_frame_byte    (rsp_frame_byte),
      .rsp_frame_last    (rsp_frame_last),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data)
   );

   always #1 clock = ~clock;

   function automatic void note_error(input string msg);
      fail_count++;
      if (fail_count <= MAX_REPORTS)
         $display("ERROR @%0t: %s", $realtime, msg);
   endfunction

   // Works out the outer frame bytes that one inner byte causes.
   task automatic encap_byte(input logic [7:0] b, input logic [15:0] len);
      logic [8*HDR_LEN-1:0] hdr;
      logic [15:0] ip_len;
      logic [15:0] udp_len;
      logic [15:0] gtp_len;
      logic [15:0] csum;
      logic [31:0] sum;
      int          eff;
      int          i;
      if (payload_pos == 0) begin
         eff = (len == 16'd0) ? 1 : int'(len);
         latched_len = eff;
         kept_len = (eff > MAX_PAYLOAD) ? MAX_PAYLOAD : eff;
         ip_len  = 16'(44 + kept_len);
         udp_len = 16'(24 + kept_len);
         gtp_len = 16'(8 + kept_len);
         // 0x4500 is version/ihl/tos, 0x4011 is ttl/protocol
         sum = 32'h4500 + ip_len + 32'h4011 + sip_m[31:16] + sip_m[15:0] +
               dip_m[31:16] + dip_m[15:0];
         sum = (sum >> 16) + (sum & 32'hFFFF);
         sum = sum + (sum >> 16);
         csum = ~sum[15:0];
         hdr = {dmac_m, smac_m, 16'h0800,
                8'h45, 8'h00, ip_len, 16'h0000, 16'h0000, 8'd64, 8'd17, csum,
                sip_m, dip_m,
                16'd12345, 16'd2152, udp_len, 16'h0000,
                8'h34, 8'hFF, gtp_len, teid_m, 16'h0000, 8'h00, 8'h85,
                8'h01, 8'h10, {2'b00, qfi_m}, 8'h00};
         for (i = 0; i < HDR_LEN; i++)
            frame_q.push_back('{fbyte: hdr[8*(HDR_LEN-1-i) +: 8], last: 1'b0});
      end
      if (payload_pos < kept_len)
         frame_q.push_back('{fbyte: b, last: (payload_pos + 1 == kept_len)});
      payload_pos++;
      if (payload_pos >= latched_len)
         payload_pos = 0;
   endtask

   always @(posedge clock) begin : drive_req
      inner_item_type nxt;
      logic           take;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            encap_byte(req_data_byte, req_packet_length);
         if (!req_valid || !req_stall) begin
            take = (inner_q.size() != 0) && ($urandom_range(99) >= send_idle_pct);
            if (take) begin
               nxt = inner_q.pop_front();
               req_data_byte <= nxt.data_byte;
               req_packet_length <= nxt.packet_length;
            end
            req_valid <= take;
         end
      end
   end

   always @(posedge clock) begin : check_rsp
      frame_beat_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (frame_q.size() == 0) begin
            note_error($sformatf("unexpected frame byte %02h last %0b",
                                 rsp_frame_byte, rsp_frame_last));
         end else begin
            want = frame_q.pop_front();
            if (rsp_frame_byte !== want.fbyte || rsp_frame_last !== want.last)
               note_error($sformatf("frame byte: expected %02h last %0b, got %02h last %0b",
                                    want.fbyte, want.last, rsp_frame_byte, rsp_frame_last));
         end
      end
      rsp_stall <= hold_off || ($urandom_range(99) < stall_pct);
   end

   // long receiver hold-off so the queue fills and the input backs up
   initial begin : receiver_hold
      wait (hold_armed);
      repeat (20) @(posedge clock);
      hold_off <= 1'b1;
      repeat (400) @(posedge clock);
      hold_off <= 1'b0;
   end

   initial begin : run_limit
      #2_000_000;
      $display("tb_gtpu_tunnel_encapsulator_unit: FAIL");
      $finish;
   end

   task automatic push_item(input logic [7:0] b, input logic [15:0] len);
      inner_q.push_back('{data_byte: b, packet_length: len});
   endtask

   // mostly well-formed packets; a few carry a stray length mid-packet
   task automatic queue_random(input int n_items);
      int count;
      int len;
      int nb;
      int k;
      int r;
      count = 0;
      while (count < n_items) begin
         r = $urandom_range(99);
         if (r < 5)
            len = 0;
         else if (r < 80)
            len = $urandom_range(12, 1);
         else if (r < 95)
            len = $urandom_range(64, 13);
         else
            len = $urandom_range(200, 65);
         nb = (len == 0) ? 1 : len;
         push_item(8'($urandom), 16'(len));
         for (k = 1; k < nb; k++)
            push_item(8'($urandom),
                      ($urandom_range(99) < 8) ? 16'($urandom) : 16'(len));
         count += nb;
      end
   endtask

   task automatic wait_drained();
      while (inner_q.size() != 0 || req_valid)
         @(posedge clock);
      while (frame_q.size() != 0)
         @(posedge clock);
      // bytes past the cut may still be in flight with nothing expected
      repeat (FLUSH_WAIT) @(posedge clock);
   endtask

   task automatic run_phase(input int idle_p, input int stall_p, input int n_items,
                            input bit long_hold);
      send_idle_pct = idle_p;
      stall_pct = stall_p;
      hold_armed = long_hold;
      queue_random(n_items);
      wait_drained();
   endtask

   task automatic write_reg(input logic [2:0] idx, input logic [47:0] val);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_TUNNEL_ID: teid_m = val[31:0];
         CSR_FLOW_QFI:  qfi_m = val[5:0];
         CSR_SRC_MAC:   smac_m = val;
         CSR_DST_MAC:   dmac_m = val;
         CSR_SRC_IP:    sip_m = val[31:0];
         CSR_DST_IP:    dip_m = val[31:0];
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_all_regs(input fill_kind_type kind);
      logic [2:0]  idx;
      logic [47:0] val;
      for (idx = CSR_TUNNEL_ID; idx <= CSR_DST_IP; idx++) begin
         case (kind)
            FILL_ONES:  val = '1;
            FILL_ZEROS: val = '0;
            default:    val = {16'($urandom), 32'($urandom)};
         endcase
         write_reg(idx, val);
      end
   endtask

   initial begin : stimulus
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // reset register values; edge lengths and odd length fields first
      push_item(8'h00, 16'd1);
      push_item(8'hFF, 16'd0);
      push_item(8'hA5, 16'd3);
      push_item(8'h5A, 16'hFFFF);
      push_item(8'h3C, 16'h0000);
      push_item(8'h80, 16'd2);
      push_item(8'h01, 16'd2);
      push_item(8'h7E, 16'd1);
      run_phase(0, 0, 50, 1'b0);

      write_all_regs(FILL_ONES);
      run_phase(65, 0, 100, 1'b0);

      write_all_regs(FILL_ZEROS);
      run_phase(0, 65, 100, 1'b1);

      write_all_regs(FILL_RANDOM);
      write_reg(CSR_SPARE_LO, {16'($urandom), 32'($urandom)});
      write_reg(CSR_SPARE_HI, {16'($urandom), 32'($urandom)});
      run_phase(14, 14, 100, 1'b0);

      write_all_regs(FILL_RANDOM);
      run_phase(0, 0, 100, 1'b0);

      if (frame_q.size() != 0)
         note_error($sformatf("%0d frame bytes never arrived", frame_q.size()));
      if (fail_count == 0)
         $display("tb_gtpu_tunnel_encapsulator_unit: PASS");
      else
         $display("tb_gtpu_tunnel_encapsulator_unit: FAIL");
      $finish;
   end

endmodule

// ===== files.f =====
hw/rtl/gtpu_pkg.sv
hw/rtl/gtpu_front.sv
hw/rtl/gtpu_fifo.sv
hw/rtl/gtpu_back.sv
hw/rtl/gtpu_tunnel_encapsulator_unit.sv
test/tb_gtpu_tunnel_encapsulator_unit.sv
